// File: rtl/fesc_pkg.sv
package fesc_pkg;

   localparam logic [7:0] FLAG_BYTE   = 8'h7E;
   localparam logic [7:0] ESC_BYTE    = 8'h7D;
   localparam logic [7:0] ESC_OF_FLAG = 8'h5E;
   localparam logic [7:0] ESC_OF_ESC  = 8'h5D;

   localparam logic REQ_ENCODE = 1'b0;
   localparam logic REQ_DECODE = 1'b1;

   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 4;

   // One classified item: up to three result bytes and their common flags.
   typedef struct packed {
      logic [1:0]                   cnt;
      logic [MAX_RESULTS-1:0][7:0]  bytes;
      logic                         has;
      logic                         err;
      logic                         last;
   } job_type;

endpackage

// File: rtl/flag_escape_byte_stuffing_codec_unit.sv
// Flag/escape byte stuffing codec, one frame byte per transfer.
// Request side: drive req_type (0 encode, 1 decode), req_data_byte and the
// frame marks, and raise req_push; a transfer happens when req_full is low.
// Result side: while rsp_empty is low the oldest result is on the rsp_ ports;
// raise rsp_pop to take it. rsp_run_last marks the last result of one request.
// A request gives zero to three results. The front classifies it in the cycle
// it is accepted and writes it into a four-entry job queue; the back stage
// sends out one result per cycle while rsp_pop takes them, from the queue head
// through the single output register. A transferred request passes through a
// queue slot and then the output register before its first result is on rsp_.
// When the result side stalls, the queue fills and req_full rises; requests
// continue to be taken while a result waits until the queue is full.
// Reset clears the held decode escape, the queue pointers and the result valid flag.
module flag_escape_byte_stuffing_codec_unit #(
   parameter int QUEUE_DEPTH = fesc_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_type,
   input  logic [7:0] req_data_byte,
   input  logic       req_frame_first,
   input  logic       req_frame_last,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_byte,
   output logic       rsp_frame_end,
   output logic       rsp_run_last,
   output logic       rsp_marker_error
);

   fesc_pkg::job_type new_job;
   fesc_pkg::job_type head_job;
   logic accept;
   logic job_push;
   logic job_pop;
   logic queue_empty;

   assign accept = req_push && !req_full;

   fesc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .req_type        (req_type),
      .req_data_byte   (req_data_byte),
      .req_frame_first (req_frame_first),
      .req_frame_last  (req_frame_last),
      .job_push        (job_push),
      .job             (new_job)
   );

   fesc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (new_job),
      .pop      (job_pop),
      .head_job (head_job),
      .full     (req_full),
      .empty    (queue_empty)
   );

   fesc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_job         (head_job),
      .queue_empty      (queue_empty),
      .queue_pop        (job_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_has_byte     (rsp_has_byte),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_run_last     (rsp_run_last),
      .rsp_marker_error (rsp_marker_error)
   );

`ifndef NO_ASSERTIONS
   a_no_byte_alone: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_has_byte) |-> (rsp_run_last && (rsp_out_byte == 8'h00)))
      else $error("result without a byte is not a lone zero result");

   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_frame_end) |-> rsp_run_last)
      else $error("frame end on a result that is not the last of its request");

   a_job_nonzero: assert property (@(posedge clock) disable iff (reset)
      job_push |-> (new_job.cnt != 2'd0))
      else $error("queued job holds no result");

   a_pop_has_job: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> !queue_empty)
      else $error("job queue read while empty");
`endif

endmodule

// File: rtl/fesc_front.sv
module fesc_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             req_type,
   input  logic [7:0]       req_data_byte,
   input  logic             req_frame_first,
   input  logic             req_frame_last,
   output logic             job_push,
   output fesc_pkg::job_type job
);

   logic esc_ff;
   logic esc_in;

   always_comb begin
      logic [1:0] n;
      logic       is_flag;
      n = '0;
      is_flag = 1'b0;
      job = '0;
      job.has = 1'b1;
      job.last = req_frame_last;
      esc_in = esc_ff;
      if (req_type == fesc_pkg::REQ_ENCODE) begin
         esc_in = 1'b0;
         if (req_frame_first) begin
            job.bytes[n] = fesc_pkg::FLAG_BYTE;
            n = n + 2'd1;
         end
         if (req_data_byte == fesc_pkg::ESC_BYTE) begin
            job.bytes[n] = fesc_pkg::ESC_BYTE;
            n = n + 2'd1;
            job.bytes[n] = fesc_pkg::ESC_OF_ESC;
            n = n + 2'd1;
         end else if (req_data_byte == fesc_pkg::FLAG_BYTE) begin
            job.bytes[n] = fesc_pkg::ESC_BYTE;
            n = n + 2'd1;
            job.bytes[n] = fesc_pkg::ESC_OF_FLAG;
            n = n + 2'd1;
         end else begin
            job.bytes[n] = req_data_byte;
            n = n + 2'd1;
         end
      end else begin
         if (req_frame_first) begin
            esc_in = 1'b0;
            if (req_data_byte == fesc_pkg::FLAG_BYTE) begin
               is_flag = 1'b1;
            end else begin
               job.err = 1'b1;
            end
         end
         if (is_flag) begin
            if (req_frame_last) begin
               job.has = 1'b0;
               n = 2'd1;
            end
         end else begin
            if (esc_in) begin
               esc_in = 1'b0;
               if (req_data_byte == fesc_pkg::ESC_OF_ESC) begin
                  job.bytes[n] = fesc_pkg::ESC_BYTE;
                  n = n + 2'd1;
               end else if (req_data_byte == fesc_pkg::ESC_OF_FLAG) begin
                  job.bytes[n] = fesc_pkg::FLAG_BYTE;
                  n = n + 2'd1;
               end else begin
                  job.bytes[n] = fesc_pkg::ESC_BYTE;
                  n = n + 2'd1;
                  if (req_data_byte == fesc_pkg::ESC_BYTE) begin
                     esc_in = 1'b1;
                  end else begin
                     job.bytes[n] = req_data_byte;
                     n = n + 2'd1;
                  end
               end
            end else if (req_data_byte == fesc_pkg::ESC_BYTE) begin
               esc_in = 1'b1;
            end else begin
               job.bytes[n] = req_data_byte;
               n = n + 2'd1;
            end
            if (req_frame_last && esc_in) begin
               job.bytes[n] = fesc_pkg::ESC_BYTE;
               n = n + 2'd1;
               esc_in = 1'b0;
            end
            if ((n == 2'd0) && job.err) begin
               job.has = 1'b0;
               n = 2'd1;
            end
         end
      end
      job.cnt = n;
   end

   assign job_push = accept && (job.cnt != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff <= 1'b0;
      end else if (accept) begin
         esc_ff <= esc_in;
      end
   end

endmodule

// File: rtl/fesc_queue.sv
module fesc_queue #(
   parameter int DEPTH = fesc_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fesc_pkg::job_type push_job,
   input  logic             pop,
   output fesc_pkg::job_type head_job,
   output logic             full,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

   fesc_pkg::job_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;

   assign full = (count_ff == DEPTH_CNT);
   assign empty = (count_ff == '0);
   assign head_job = slot_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/fesc_back.sv
module fesc_back (
   input  logic             clock,
   input  logic             reset,
   input  fesc_pkg::job_type head_job,
   input  logic             queue_empty,
   output logic             queue_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_has_byte,
   output logic             rsp_frame_end,
   output logic             rsp_run_last,
   output logic             rsp_marker_error
);

   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic [7:0] byte_ff;
   logic       has_ff, end_ff, run_ff, err_ff;
   logic       load;
   logic       is_last;

   assign rsp_empty = !valid_ff;
   assign load = !queue_empty && (!valid_ff || rsp_pop);
   assign is_last = (idx_ff == (head_job.cnt - 2'd1));
   assign queue_pop = load && is_last;

   always_comb begin
      valid_in = valid_ff;
      idx_in = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= head_job.bytes[idx_ff];
         has_ff <= head_job.has;
         run_ff <= is_last;
         end_ff <= is_last && head_job.last;
         err_ff <= head_job.err;
      end
   end

   assign rsp_out_byte = byte_ff;
   assign rsp_has_byte = has_ff;
   assign rsp_frame_end = end_ff;
   assign rsp_run_last = run_ff;
   assign rsp_marker_error = err_ff;

endmodule
